// ===== rtl/core/mcp_pkg.sv =====
package mcp_pkg;

    // Parser phase; the fourth code behaves as mnemonic collection
    typedef enum logic [1:0] {
        PH_MNEMONIC = 2'd0,
        PH_ARGUMENT = 2'd1,
        PH_SKIP     = 2'd2
    } phase_t;

    // Matched mnemonic
    typedef enum logic [1:0] {
        CMD_FRQ = 2'd0,
        CMD_AGC = 2'd1,
        CMD_ATN = 2'd2
    } command_t;

    // Result event codes
    localparam logic [2:0] EV_FREQ_REPORT = 3'd0;
    localparam logic [2:0] EV_GAIN_SET    = 3'd1;
    localparam logic [2:0] EV_GAIN_QUERY  = 3'd2;
    localparam logic [2:0] EV_ATTEN_SET   = 3'd3;
    localparam logic [2:0] EV_ATTEN_QUERY = 3'd4;

    // Characters
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_QUERY     = 8'h3F;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_LO  = 8'h60;
    localparam logic [7:0] CH_LOWER_HI  = 8'h7B;
    localparam logic [7:0] CASE_BIT     = 8'h20;

    // Reset values
    localparam logic [31:0] MAX_FREQ_RESET = 32'd3000;
    localparam logic [31:0] FREQ_RESET     = 32'd200;

endpackage

// ===== rtl/core/mnemonic_command_parser_top.sv =====
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+---------------------------------
// input     | in        | in_valid / in_stall  | ch [7:0]
// output    | out       | out_valid / out_stall| event_res [2:0], value [31:0]
// config    | in        | cfg_we               | cfg_data [31:0] (max frequency)
//
// One word is taken per cycle while in_stall is low; a terminator's result appears
// in the output register on the next cycle. A single parser state update lies
// between input and the output register (accumulator multiply-by-ten and limit
// compare).
// in_stall rises only while a result is held and the output side stalls.
// Reset (rst_n low, asynchronous) returns the parser to mnemonic collection,
// frequency to 200 and the limit to 3000; the output register empties.
module mnemonic_command_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [31:0] value,
    // configuration
    input  logic        cfg_we,
    input  logic [31:0] cfg_data
);

    mcp_pkg::phase_t   phase_reg, phase_next;
    mcp_pkg::command_t command_reg, command_next;
    logic [1:0]  letter_count_reg, letter_count_next;
    logic [15:0] first_letters_reg, first_letters_next;
    logic        arg_started_reg, arg_started_next;
    logic        is_query_reg, is_query_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] freq_reg, freq_next;
    logic [31:0] max_freq_reg;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  event_reg, event_next;
    logic [31:0] value_reg, value_next;

    logic        accept;
    logic        drop;
    logic [7:0]  ch_up;
    logic        is_term;
    logic        is_nl;
    logic        matched;
    logic        emit;
    logic [2:0]  ev;
    logic [31:0] acc_step;
    mcp_pkg::command_t match_cmd;

    // Hold the input while a result waits and the output side stalls
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Drop spaces and NULs; fold lower case to upper case
    assign drop  = (ch == mcp_pkg::CH_SPACE) || (ch == mcp_pkg::CH_NUL);
    assign ch_up = (ch > mcp_pkg::CH_LOWER_LO && ch < mcp_pkg::CH_LOWER_HI)
                   ? (ch & ~mcp_pkg::CASE_BIT) : ch;
    assign is_nl   = (ch_up == mcp_pkg::CH_NEWLINE);
    assign is_term = is_nl || (ch_up == mcp_pkg::CH_SEMICOLON);

    // Three-letter match on the two stored letters plus this one
    always_comb
    begin
        matched   = 1'b1;
        match_cmd = mcp_pkg::CMD_FRQ;
        if (first_letters_reg == {8'h46, 8'h52} && ch_up == 8'h51)
            match_cmd = mcp_pkg::CMD_FRQ;
        else if (first_letters_reg == {8'h41, 8'h47} && ch_up == 8'h43)
            match_cmd = mcp_pkg::CMD_AGC;
        else if (first_letters_reg == {8'h41, 8'h54} && ch_up == 8'h4E)
            match_cmd = mcp_pkg::CMD_ATN;
        else
            matched = 1'b0;
    end

    // acc * 10 + ch - '0', wrapping at 32 bits
    assign acc_step = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                      + {24'd0, ch_up} - {24'd0, mcp_pkg::CH_ZERO};

    // Terminator event code
    always_comb
    begin
        emit = 1'b1;
        ev   = mcp_pkg::EV_FREQ_REPORT;
        unique case (command_reg)
            mcp_pkg::CMD_FRQ:
            begin
                ev   = mcp_pkg::EV_FREQ_REPORT;
                emit = is_query_reg;
            end
            mcp_pkg::CMD_AGC:
                ev = is_query_reg ? mcp_pkg::EV_GAIN_QUERY : mcp_pkg::EV_GAIN_SET;
            default:
                ev = is_query_reg ? mcp_pkg::EV_ATTEN_QUERY : mcp_pkg::EV_ATTEN_SET;
        endcase
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept && !drop)
        begin
            unique case (phase_reg)
                mcp_pkg::PH_SKIP:
                    if (is_nl)
                        phase_next = mcp_pkg::PH_SKIP == phase_reg
                                     ? mcp_pkg::PH_MNEMONIC : phase_reg;
                mcp_pkg::PH_ARGUMENT:
                    if (is_term)
                        phase_next = mcp_pkg::PH_MNEMONIC;
                default:
                begin
                    phase_next = mcp_pkg::PH_MNEMONIC;
                    if (!is_nl && letter_count_reg >= 2'd2)
                        phase_next = matched ? mcp_pkg::PH_ARGUMENT : mcp_pkg::PH_SKIP;
                end
            endcase
        end
    end

    // Datapath and result
    always_comb
    begin
        command_next       = command_reg;
        letter_count_next  = letter_count_reg;
        first_letters_next = first_letters_reg;
        arg_started_next   = arg_started_reg;
        is_query_next      = is_query_reg;
        acc_next           = acc_reg;
        freq_next          = freq_reg;
        event_next         = event_reg;
        value_next         = value_reg;
        out_valid_next     = out_valid_reg && out_stall;

        if (accept)
        begin
            out_valid_next = 1'b0;
            if (!drop)
            begin
                unique case (phase_reg)
                    mcp_pkg::PH_SKIP:
                        if (is_nl)
                        begin
                            letter_count_next  = 2'd0;
                            first_letters_next = 16'd0;
                        end
                    mcp_pkg::PH_ARGUMENT:
                        if (is_term)
                        begin
                            if (command_reg == mcp_pkg::CMD_FRQ && !is_query_reg
                                && acc_reg <= max_freq_reg)
                                freq_next = acc_reg;
                            out_valid_next     = emit;
                            event_next         = ev;
                            value_next         = (ev == mcp_pkg::EV_FREQ_REPORT)
                                                 ? freq_reg : 32'd0;
                            letter_count_next  = 2'd0;
                            first_letters_next = 16'd0;
                            arg_started_next   = 1'b0;
                            is_query_next      = 1'b0;
                            acc_next           = 32'd0;
                        end
                        else
                        begin
                            logic q;
                            q = is_query_reg;
                            if (!arg_started_reg)
                            begin
                                arg_started_next = 1'b1;
                                if (ch_up == mcp_pkg::CH_QUERY)
                                    q = 1'b1;
                            end
                            is_query_next = q;
                            if (!q)
                                acc_next = acc_step;
                        end
                    default:
                        if (is_nl)
                        begin
                            letter_count_next  = 2'd0;
                            first_letters_next = 16'd0;
                        end
                        else if (letter_count_reg < 2'd2)
                        begin
                            first_letters_next = {first_letters_reg[7:0], ch_up};
                            letter_count_next  = letter_count_reg + 2'd1;
                        end
                        else
                        begin
                            letter_count_next  = 2'd0;
                            first_letters_next = 16'd0;
                            if (matched)
                            begin
                                command_next     = match_cmd;
                                arg_started_next = 1'b0;
                                is_query_next    = 1'b0;
                                acc_next         = 32'd0;
                            end
                        end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= mcp_pkg::PH_MNEMONIC;
            command_reg       <= mcp_pkg::CMD_FRQ;
            letter_count_reg  <= 2'd0;
            first_letters_reg <= 16'd0;
            arg_started_reg   <= 1'b0;
            is_query_reg      <= 1'b0;
            acc_reg           <= 32'd0;
            freq_reg          <= mcp_pkg::FREQ_RESET;
            max_freq_reg      <= mcp_pkg::MAX_FREQ_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            command_reg       <= command_next;
            letter_count_reg  <= letter_count_next;
            first_letters_reg <= first_letters_next;
            arg_started_reg   <= arg_started_next;
            is_query_reg      <= is_query_next;
            acc_reg           <= acc_next;
            freq_reg          <= freq_next;
            out_valid_reg     <= out_valid_next;
            if (cfg_we)
                max_freq_reg <= cfg_data;
        end
    end

    // Result payload: no reset needed
    always_ff @(posedge clk)
    begin
        event_reg <= event_next;
        value_reg <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign value     = value_reg;

endmodule

// ===== bench/mnemonic_command_parser_top_test.sv =====
module mnemonic_command_parser_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Run length and pressure knobs
    localparam int WORDS_PER_PHASE = 300;
    localparam int NUM_PHASES      = 6;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 300000;

    // Mnemonics packed the way the parser sees them: first letter in the top byte
    localparam logic [23:0] MN_FRQ = "FRQ";
    localparam logic [23:0] MN_AGC = "AGC";
    localparam logic [23:0] MN_ATN = "ATN";

    typedef struct packed {
        logic [2:0]  ev;
        logic [31:0] val;
    } parser_event_t;

    // Scoreboard: tracks the parser state word by word, queues the events
    // that each accepted word causes and checks them in order.
    class command_scoreboard;
        mcp_pkg::phase_t   phase;
        logic [1:0]        letter_count;
        logic [15:0]       first_letters;
        mcp_pkg::command_t command;
        bit                argument_started;
        bit                is_query;
        logic [31:0]       accumulator;
        logic [31:0]       frequency;
        logic [31:0]       max_frequency;
        parser_event_t     expected_events [$];
        int                errors;

        function new();
            phase            = mcp_pkg::PH_MNEMONIC;
            letter_count     = '0;
            first_letters    = '0;
            command          = mcp_pkg::CMD_FRQ;
            argument_started = 1'b0;
            is_query         = 1'b0;
            accumulator      = '0;
            frequency        = mcp_pkg::FREQ_RESET;
            max_frequency    = mcp_pkg::MAX_FREQ_RESET;
            errors           = 0;
        endfunction

        function void set_limit(logic [31:0] limit);
            max_frequency = limit;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void restart_mnemonic();
            phase         = mcp_pkg::PH_MNEMONIC;
            letter_count  = '0;
            first_letters = '0;
        endfunction

        function void take_char(logic [7:0] raw);
            logic [7:0]    c;
            logic [23:0]   mnemonic;
            parser_event_t e;
            bit            emit;
            c = raw;
            if (c == mcp_pkg::CH_SPACE || c == mcp_pkg::CH_NUL)
                return;
            if (c > mcp_pkg::CH_LOWER_LO && c < mcp_pkg::CH_LOWER_HI)
                c = c & ~mcp_pkg::CASE_BIT;
            case (phase)
                mcp_pkg::PH_SKIP:
                begin
                    if (c == mcp_pkg::CH_NEWLINE)
                        restart_mnemonic();
                end
                mcp_pkg::PH_ARGUMENT:
                begin
                    if (c == mcp_pkg::CH_SEMICOLON || c == mcp_pkg::CH_NEWLINE)
                    begin
                        emit = 1'b1;
                        e.ev = mcp_pkg::EV_FREQ_REPORT;
                        case (command)
                            mcp_pkg::CMD_FRQ:
                            begin
                                // a set is silent; out-of-range values are dropped
                                if (!is_query)
                                begin
                                    emit = 1'b0;
                                    if (accumulator <= max_frequency)
                                        frequency = accumulator;
                                end
                            end
                            mcp_pkg::CMD_AGC:
                                e.ev = is_query ? mcp_pkg::EV_GAIN_QUERY
                                                : mcp_pkg::EV_GAIN_SET;
                            default:
                                e.ev = is_query ? mcp_pkg::EV_ATTEN_QUERY
                                                : mcp_pkg::EV_ATTEN_SET;
                        endcase
                        e.val = (e.ev == mcp_pkg::EV_FREQ_REPORT) ? frequency : 32'd0;
                        if (emit)
                            expected_events.push_back(e);
                        restart_mnemonic();
                        argument_started = 1'b0;
                        is_query         = 1'b0;
                        accumulator      = '0;
                    end
                    else
                    begin
                        if (!argument_started)
                        begin
                            argument_started = 1'b1;
                            if (c == mcp_pkg::CH_QUERY)
                                is_query = 1'b1;
                        end
                        // no digit check: every character folds in, wrapping at 32 bits
                        if (!is_query)
                            accumulator = accumulator * 32'd10 + {24'd0, c}
                                          - {24'd0, mcp_pkg::CH_ZERO};
                    end
                end
                default:
                begin
                    phase = mcp_pkg::PH_MNEMONIC;
                    if (c == mcp_pkg::CH_NEWLINE)
                    begin
                        restart_mnemonic();
                    end
                    else if (letter_count < 2'd2)
                    begin
                        first_letters = {first_letters[7:0], c};
                        letter_count  = letter_count + 2'd1;
                    end
                    else
                    begin
                        mnemonic = {first_letters, c};
                        restart_mnemonic();
                        if (mnemonic == MN_FRQ || mnemonic == MN_AGC
                            || mnemonic == MN_ATN)
                        begin
                            if (mnemonic == MN_FRQ)
                                command = mcp_pkg::CMD_FRQ;
                            else if (mnemonic == MN_AGC)
                                command = mcp_pkg::CMD_AGC;
                            else
                                command = mcp_pkg::CMD_ATN;
                            phase            = mcp_pkg::PH_ARGUMENT;
                            argument_started = 1'b0;
                            is_query         = 1'b0;
                            accumulator      = '0;
                        end
                        else
                        begin
                            phase = mcp_pkg::PH_SKIP;
                        end
                    end
                end
            endcase
        endfunction

        function void check_event(logic [2:0] ev, logic [31:0] val);
            parser_event_t e;
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected event %0d value %0d", $time, ev, val);
                errors++;
                return;
            end
            e = expected_events.pop_front();
            if (e.ev !== ev)
            begin
                $display("%0t: event mismatch: expected %0d, actual %0d", $time, e.ev, ev);
                errors++;
            end
            if (e.val !== val)
            begin
                $display("%0t: value mismatch: expected %0d, actual %0d", $time, e.val, val);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  event_res;
    logic [31:0] value;
    logic        cfg_we;
    logic [31:0] cfg_data;

    command_scoreboard sb = new();

    bit in_gaps_on  = 1'b1;    // sender may idle
    bit out_gaps_on = 1'b1;    // receiver may stall
    bit hold_req    = 1'b0;    // ask the receiver for one long hold-off
    int words_sent  = 0;       // counts only words the parser does not drop
    int cycle_count = 0;

    string mnemonic_text [3] = '{"FRQ", "AGC", "ATN"};
    string letter_pool       = "FRQAGCTN";

    mnemonic_command_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .event_res (event_res),
        .value     (value),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: the slowest correct run is far below this
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sample results at the rising edge; a word moves when valid is high and stall low
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_event(event_res, value);
    end

    // Receiver: random stalls, or one long hold-off on request so the parser backs up
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_stall <= out_gaps_on && ($urandom_range(99) < 23);
        end
    end

    // Offer one word and hold it until the parser takes it
    task automatic send_char(input logic [7:0] c);
        @(negedge clk);
        if (in_gaps_on && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < 23);
        end
        in_valid <= 1'b1;
        ch       <= c;
        do @(posedge clk); while (in_stall);
        sb.take_char(c);
        if (c != mcp_pkg::CH_SPACE && c != mcp_pkg::CH_NUL)
            words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_char(8'($urandom_range(255)));
    endtask

    // Drop valid and wait until every queued event has come out, then wait on
    // for a word still in flight that causes no event
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] limit);
        drain();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= limit;
        @(posedge clk);
        sb.set_limit(limit);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mnemonic letter in random case, now and then behind a dropped filler
    task automatic send_letter(input logic [7:0] c);
        if ($urandom_range(9) == 0)
            send_char($urandom_range(1) ? mcp_pkg::CH_SPACE : mcp_pkg::CH_NUL);
        send_char($urandom_range(1) ? (c | mcp_pkg::CASE_BIT) : c);
    endtask

    // One line of random content: mostly well-formed commands, the rest noise
    // and broken mnemonics
    task automatic send_command();
        int          kind;
        int          pick;
        int          arg_kind;
        longint      near_limit;
        kind = $urandom_range(99);
        if (kind < 72)
        begin
            pick = $urandom_range(2);
            for (int i = 0; i < 3; i++)
                send_letter(mnemonic_text[pick][i]);
            arg_kind = $urandom_range(9);
            if (arg_kind < 3)
            begin
                // query; the rest of the argument is ignored
                send_char(mcp_pkg::CH_QUERY);
                send_noise($urandom_range(2));
            end
            else if (arg_kind < 7)
            begin
                if (pick == 0 && $urandom_range(1))
                begin
                    // hit the limit, one past it and one below it
                    near_limit = longint'(sb.max_frequency)
                                 + longint'($urandom_range(2)) - 64'sd1;
                    if (near_limit < 0)
                        near_limit = 0;
                    send_text($sformatf("%0d", near_limit));
                end
                else
                begin
                    for (int i = $urandom_range(12); i > 0; i--)
                        send_char(8'(mcp_pkg::CH_ZERO + $urandom_range(9)));
                end
            end
            else if (arg_kind < 8)
            begin
                // empty argument
            end
            else
            begin
                send_noise($urandom_range(1, 4));
            end
            send_char($urandom_range(1) ? mcp_pkg::CH_SEMICOLON : mcp_pkg::CH_NEWLINE);
        end
        else if (kind < 86)
        begin
            send_noise($urandom_range(1, 4));
        end
        else
        begin
            // partial or mismatched mnemonic, then end the line
            for (int i = $urandom_range(1, 3); i > 0; i--)
                send_letter(letter_pool[$urandom_range(7)]);
            send_noise($urandom_range(2));
            send_char(mcp_pkg::CH_NEWLINE);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        ch       = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: dropped NUL and space, lower case, every event, query tail ignored,
        // newline inside a mnemonic, ';' as a mnemonic letter, FRQ set and empty set
        send_char(mcp_pkg::CH_NUL);
        send_text("fRq ?;agc;AGC?\nATN;atn?");
        send_char(8'hFF);
        send_text("\nA\n;AG\nFRQ9;FRQ?;FRQ;frq?\n");

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                1: write_limit(32'hFFFF_FFFF);
                2: write_limit(32'd0);
                3: write_limit($urandom_range(9999));
                4: write_limit($urandom());
                5: write_limit(mcp_pkg::MAX_FREQ_RESET);
                default: ;
            endcase
            // one phase runs with no idling on either side
            in_gaps_on  = (p != 2);
            out_gaps_on = (p != 2);
            if (p == 1)
            begin
                // hold the receiver off and keep offering queries until input stalls
                hold_req = 1'b1;
                for (int i = 0; i < 40; i++)
                    send_text("AGC?;");
            end
            while (words_sent < (p + 1) * WORDS_PER_PHASE)
                send_command();
        end

        drain();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mcp_pkg.sv
rtl/core/mnemonic_command_parser_top.sv
bench/mnemonic_command_parser_top_test.sv
